FILE: src/mafr_pkg.sv
// ----------------------------------------------------------------------------
// mafr_pkg
// Shared types and constants for the Modbus ASCII frame receiver.
// ----------------------------------------------------------------------------
package mafr_pkg;

    // Frame status codes, in check priority order
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_CHAR = 2'd1,
        ST_LENGTH   = 2'd2,
        ST_LRC      = 2'd3
    } status_t;

    // Character position within the frame header / delay line
    localparam logic [1:0] POS_START  = 2'd0;
    localparam logic [1:0] POS_FILL0  = 2'd1;
    localparam logic [1:0] POS_FILL1  = 2'd2;
    localparam logic [1:0] POS_STREAM = 2'd3;

    // ASCII bounds for hex digits
    localparam logic [7:0] CHAR_0  = 8'h30;
    localparam logic [7:0] CHAR_9  = 8'h39;
    localparam logic [7:0] CHAR_UA = 8'h41;
    localparam logic [7:0] CHAR_UF = 8'h46;
    localparam logic [7:0] CHAR_LA = 8'h61;
    localparam logic [7:0] CHAR_LF = 8'h66;

    // Letter digit offset: low nibble of 'A'/'a' is 1, value is 10
    localparam logic [3:0] LETTER_ADJ = 4'd9;

    // Result queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_kind;
        status_t    frame_status;
        logic       last_of_frame;
    } result_t;

    // Per-character push request from the decoder to the queue
    typedef struct packed {
        logic       data_valid;
        logic       status_valid;
        logic [7:0] data_byte;
        status_t    status;
    } push_t;

endpackage

FILE: src/mafr_decode.sv
// ----------------------------------------------------------------------------
// mafr_decode
// Per-character frame state: start drop, CR LF delay, hex pairing, LRC sum.
// ----------------------------------------------------------------------------
module mafr_decode (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          accept,
    input  logic [7:0]    rx_char,
    input  logic          frame_end,
    output mafr_pkg::push_t push
);

    logic [1:0] pos_reg,     pos_next;
    logic [7:0] dly0_reg,    dly0_next;
    logic [7:0] dly1_reg,    dly1_next;
    logic [3:0] hi_reg,      hi_next;
    logic       phase_reg,   phase_next;
    logic [7:0] held_reg,    held_next;
    logic       hvalid_reg,  hvalid_next;
    logic [7:0] sum_reg,     sum_next;
    logic       bad_reg,     bad_next;

    logic [7:0] oldest;
    logic       is_num, is_up, is_lo, is_hex;
    logic [3:0] nib;
    logic [7:0] new_byte;

    assign oldest   = dly0_reg;
    assign is_num   = (oldest >= mafr_pkg::CHAR_0)  && (oldest <= mafr_pkg::CHAR_9);
    assign is_up    = (oldest >= mafr_pkg::CHAR_UA) && (oldest <= mafr_pkg::CHAR_UF);
    assign is_lo    = (oldest >= mafr_pkg::CHAR_LA) && (oldest <= mafr_pkg::CHAR_LF);
    assign is_hex   = is_num | is_up | is_lo;
    assign nib      = is_num ? oldest[3:0]
                    : (is_up | is_lo) ? oldest[3:0] + mafr_pkg::LETTER_ADJ
                    : 4'd0;
    assign new_byte = {hi_reg, nib};

    always_comb begin
        pos_next    = pos_reg;
        dly0_next   = dly0_reg;
        dly1_next   = dly1_reg;
        hi_next     = hi_reg;
        phase_next  = phase_reg;
        held_next   = held_reg;
        hvalid_next = hvalid_reg;
        sum_next    = sum_reg;
        bad_next    = bad_reg;

        push              = '0;
        push.data_byte    = held_reg;
        push.status       = mafr_pkg::ST_OK;

        if (accept) begin
            case (pos_reg)
                mafr_pkg::POS_START: begin
                    pos_next = mafr_pkg::POS_FILL0;
                end
                mafr_pkg::POS_FILL0: begin
                    dly0_next = rx_char;
                    pos_next  = mafr_pkg::POS_FILL1;
                end
                mafr_pkg::POS_FILL1: begin
                    dly1_next = rx_char;
                    pos_next  = mafr_pkg::POS_STREAM;
                end
                default: begin
                    // steady state: oldest char leaves the delay as payload
                    dly0_next = dly1_reg;
                    dly1_next = rx_char;
                    if (!is_hex) begin
                        bad_next = 1'b1;
                    end
                    if (!phase_reg) begin
                        hi_next    = nib;
                        phase_next = 1'b1;
                    end else begin
                        phase_next      = 1'b0;
                        push.data_valid = hvalid_reg;
                        held_next       = new_byte;
                        hvalid_next     = 1'b1;
                        sum_next        = sum_reg + new_byte;
                    end
                end
            endcase

            if (frame_end) begin
                push.status_valid = 1'b1;
                if (bad_next) begin
                    push.status = mafr_pkg::ST_BAD_CHAR;
                end else if (phase_next || !hvalid_next) begin
                    push.status = mafr_pkg::ST_LENGTH;
                end else if (sum_next != 8'd0) begin
                    push.status = mafr_pkg::ST_LRC;
                end else begin
                    push.status = mafr_pkg::ST_OK;
                end
                // back to the idle frame state
                pos_next    = mafr_pkg::POS_START;
                dly0_next   = 8'd0;
                dly1_next   = 8'd0;
                hi_next     = 4'd0;
                phase_next  = 1'b0;
                held_next   = 8'd0;
                hvalid_next = 1'b0;
                sum_next    = 8'd0;
                bad_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= mafr_pkg::POS_START;
            dly0_reg   <= 8'd0;
            dly1_reg   <= 8'd0;
            hi_reg     <= 4'd0;
            phase_reg  <= 1'b0;
            held_reg   <= 8'd0;
            hvalid_reg <= 1'b0;
            sum_reg    <= 8'd0;
            bad_reg    <= 1'b0;
        end else begin
            pos_reg    <= pos_next;
            dly0_reg   <= dly0_next;
            dly1_reg   <= dly1_next;
            hi_reg     <= hi_next;
            phase_reg  <= phase_next;
            held_reg   <= held_next;
            hvalid_reg <= hvalid_next;
            sum_reg    <= sum_next;
            bad_reg    <= bad_next;
        end
    end

endmodule

FILE: src/mafr_queue.sv
// ----------------------------------------------------------------------------
// mafr_queue
// Small result queue: takes up to two results per cycle, releases one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module mafr_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  mafr_pkg::push_t   push,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output mafr_pkg::result_t out_result
);

    mafr_pkg::result_t               mem_reg [mafr_pkg::QDEPTH];
    logic [mafr_pkg::QPTR_W-1:0]     wr_reg, wr_next;
    logic [mafr_pkg::QPTR_W-1:0]     rd_reg, rd_next;
    logic [mafr_pkg::QCNT_W-1:0]     cnt_reg, cnt_next;

    mafr_pkg::result_t               data_res, stat_res;
    logic [mafr_pkg::QPTR_W-1:0]     stat_ptr;
    logic                            pop;
    logic [mafr_pkg::QCNT_W-1:0]     n_push;

    always_comb begin
        data_res               = '0;
        data_res.out_byte      = push.data_byte;
        data_res.frame_status  = mafr_pkg::ST_OK;
        stat_res               = '0;
        stat_res.out_kind      = 1'b1;
        stat_res.frame_status  = push.status;
        stat_res.last_of_frame = 1'b1;
    end

    assign stat_ptr  = wr_reg + mafr_pkg::QPTR_W'(push.data_valid);
    assign n_push    = mafr_pkg::QCNT_W'(push.data_valid) + mafr_pkg::QCNT_W'(push.status_valid);
    assign out_valid = (cnt_reg != '0);
    assign out_result = mem_reg[rd_reg];
    assign pop       = out_valid & out_ready;
    // room for the worst case of two results from one character
    assign room      = (cnt_reg <= mafr_pkg::QCNT_W'(mafr_pkg::QDEPTH - 2));

    assign wr_next  = wr_reg + mafr_pkg::QPTR_W'(n_push);
    assign rd_next  = rd_reg + mafr_pkg::QPTR_W'(pop);
    assign cnt_next = cnt_reg + n_push - mafr_pkg::QCNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (push.data_valid) begin
            mem_reg[wr_reg] <= data_res;
        end
        if (push.status_valid) begin
            mem_reg[stat_ptr] <= stat_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

FILE: src/modbus_ascii_frame_receiver.sv
// ----------------------------------------------------------------------------
// modbus_ascii_frame_receiver
// Modbus ASCII frame receiver: hex decode, LRC check, data byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel takes one received character per request; s_tlast marks
//   the last character of the frame. The first character (start mark) is
//   dropped and the last two (CR LF) are stripped through a two-character
//   delay. Remaining characters must be hex digits and pair into bytes.
//   Master channel emits decoded data bytes (m_tuser = 0); the final byte
//   (LRC) is never emitted. Each frame closes with a status request
//   (m_tuser = 1, m_tlast = 1) carrying ok / non-hex / length / LRC error.
//   Results pass through the registered result queue; the path from an
//   accepted character into the queue is combinational.
//   Throughput: one character per cycle; at most two results per character
//   go into a four-entry result queue, so s_tready stays high while the
//   queue holds two entries or fewer and the master side drains one per
//   cycle.
//   Stall: when m_tready is low the queue fills and s_tready drops; no
//   result is lost or repeated.
//   Reset: aresetn low clears the frame state and empties the queue; the
//   next character accepted is taken as a start mark.
// ----------------------------------------------------------------------------
module modbus_ascii_frame_receiver (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_char
    input  logic        s_tlast,   // frame_end

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [9:8] frame_status, rest zero
    output logic        m_tuser,   // out_kind
    output logic        m_tlast    // last_of_frame
);

    logic              accept;
    logic              room;
    mafr_pkg::push_t   push;
    mafr_pkg::result_t head;

    assign s_tready = room;
    assign accept   = s_tvalid & room;

    // Character decode and frame state
    mafr_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .rx_char   (s_tdata),
        .frame_end (s_tlast),
        .push      (push)
    );

    // Result queue; decouples the master side from character intake
    mafr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .room       (room),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (head)
    );

    assign m_tdata = {6'd0, head.frame_status, head.out_byte};
    assign m_tuser = head.out_kind;
    assign m_tlast = head.last_of_frame;

endmodule

FILE: src/mafr_checker.sv
// ----------------------------------------------------------------------------
// mafr_checker
// Port-level checks for the Modbus ASCII frame receiver.
// ----------------------------------------------------------------------------
module mafr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // stalled result stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    // a waiting request keeps its character
    a_hold_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tlast))
        else $error("slave request changed while waiting");

    // data bytes never close a frame and carry no status
    a_data_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> !m_tlast && m_tdata[15:8] == 8'd0)
        else $error("data result with status or tlast");

    // status results close the frame and carry no byte
    a_status_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast && m_tdata[7:0] == 8'd0
                                && m_tdata[15:10] == 6'd0)
        else $error("malformed status result");

    // right after reset the queue is empty and intake is open
    a_reset_empty: assert property (@(posedge aclk)
        $rose(aresetn) |-> !m_tvalid && s_tready)
        else $error("queue not empty after reset");

endmodule

bind modbus_ascii_frame_receiver mafr_checker u_mafr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
